// ----- hdl/assert_macros.svh -----
// assertion macros used by srts_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is low
`define SRTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define SRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/srts_pkg.sv -----
// types, constants and helpers for the radix-to-symbols block
// no dependencies
`timescale 1ns / 1ps
package srts_pkg;
   localparam int unsigned MaxRadixDefault = 16;
   localparam int unsigned MaxDigits = 63;
   localparam int unsigned MagWidth = 63;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned RadixWidth = 5;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned CountWidth = 6;
   localparam int unsigned SymbolWidth = 8;
   localparam int unsigned NumSymbols = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_RADIX = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SYMBOLS_LOW = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   localparam logic [SymbolWidth-1:0] SIGN_PLUS = 8'h2B;
   localparam logic [SymbolWidth-1:0] SIGN_MINUS = 8'h2D;

   typedef struct packed {
      logic neg;
      logic [MagWidth-1:0] mag;
   } work_type;

   typedef struct packed {
      logic [RadixWidth-1:0] radix;
      logic [2*CsrDataWidth-1:0] symbols;
   } cfg_type;

   function automatic logic [SymbolWidth-1:0] symbol_of(
      input logic [2*CsrDataWidth-1:0] symbols, input logic [DigitWidth-1:0] d);
      symbol_of = symbols[d*SymbolWidth +: SymbolWidth];
   endfunction
endpackage

// ----- hdl/srts_if.sv -----
// valid/ready channel interfaces for values in and symbols out
// depends on srts_pkg
`timescale 1ns / 1ps
interface srts_req_if;
   import srts_pkg::*;
   logic valid;
   logic ready;
   logic signed [ValueWidth-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface srts_rsp_if;
   import srts_pkg::*;
   logic valid;
   logic ready;
   logic [SymbolWidth-1:0] symbol;
   logic last;
   modport source (output valid, output symbol, output last, input ready);
   modport sink (input valid, input symbol, input last, output ready);
endinterface

// ----- hdl/signed_radix_to_symbols.sv -----
// steps: load, division into digits in the shared divider (one quotient bit a cycle),
// the sign step, a minus sign when negative, then a read, load and wait per digit symbol
// throughput: one value at a time in the back end; a two-entry queue holds up to two more
// reset: synchronous, active high; clears control state and config registers
`timescale 1ns / 1ps
module signed_radix_to_symbols #(
   parameter int unsigned MAX_RADIX = srts_pkg::MaxRadixDefault
) (
   input  logic clock,
   input  logic reset,
   srts_req_if.sink   req_chan,
   srts_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [srts_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [srts_pkg::CsrDataWidth-1:0] csr_wdata
);
   import srts_pkg::*;

   logic [RadixWidth-1:0] radix_ff;
   logic [CsrDataWidth-1:0] sym_low_ff, sym_high_ff;
   cfg_type cfg;
   logic q_full, q_push, q_pop, q_empty;
   work_type q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
         sym_low_ff <= '0;
         sym_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIX: radix_ff <= csr_wdata[RadixWidth-1:0];
            CSR_SYMBOLS_LOW: sym_low_ff <= csr_wdata;
            CSR_SYMBOLS_HIGH: sym_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.radix = radix_ff;
   assign cfg.symbols = {sym_high_ff, sym_low_ff};

   srts_front #(.MAX_RADIX(MAX_RADIX)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req_chan.valid), .in_ready(req_chan.ready), .in_value(req_chan.value),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   srts_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_out)
   );

   srts_back #(.MAX_RADIX(MAX_RADIX)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_empty(q_empty), .q_pop(q_pop), .q_data(q_out),
      .out_valid(rsp_chan.valid), .out_ready(rsp_chan.ready),
      .out_symbol(rsp_chan.symbol), .out_last(rsp_chan.last)
   );
endmodule

// ----- hdl/srts_front.sv -----
// front end: takes values, checks the symbol table, saturates magnitude
// depends on srts_pkg
`timescale 1ns / 1ps
module srts_front #(
   parameter int unsigned MAX_RADIX = srts_pkg::MaxRadixDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  srts_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [srts_pkg::ValueWidth-1:0] in_value,
   input  logic                q_full,
   output logic                q_push,
   output srts_pkg::work_type  q_data
);
   import srts_pkg::*;

   logic [RadixWidth-1:0] eff_radix;
   logic table_ok;
   logic [ValueWidth-1:0] neg_value;
   logic accept_ff;

   assign eff_radix = (cfg.radix > RadixWidth'(MAX_RADIX)) ?
                      RadixWidth'(MAX_RADIX) : cfg.radix;

   always_comb begin
      table_ok = (eff_radix >= RadixWidth'(2));
      for (int i = 0; i < NumSymbols; i++) begin
         if (RadixWidth'(i) < eff_radix) begin
            if (symbol_of(cfg.symbols, DigitWidth'(i)) == SIGN_PLUS ||
                symbol_of(cfg.symbols, DigitWidth'(i)) == SIGN_MINUS)
               table_ok = 1'b0;
         end
         for (int j = i + 1; j < NumSymbols; j++) begin
            if (RadixWidth'(j) < eff_radix &&
                symbol_of(cfg.symbols, DigitWidth'(i)) ==
                symbol_of(cfg.symbols, DigitWidth'(j)))
               table_ok = 1'b0;
         end
      end
   end

   // ready drops for one cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         accept_ff <= 1'b0;
      end else begin
         accept_ff <= 1'b1;
      end
   end

   assign in_ready = accept_ff && !q_full;
   assign q_push = in_valid && in_ready && table_ok;
   assign neg_value = 64'd0 - ValueWidth'(in_value);

   always_comb begin
      q_data.neg = in_value[ValueWidth-1];
      if (!in_value[ValueWidth-1])
         q_data.mag = in_value[MagWidth-1:0];
      else if (neg_value[ValueWidth-1])
         q_data.mag = '1;  // most negative value saturates
      else
         q_data.mag = neg_value[MagWidth-1:0];
   end
endmodule

// ----- hdl/srts_queue.sv -----
// two-entry queue between front and back ends
// depends on srts_pkg
`timescale 1ns / 1ps
module srts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  srts_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output srts_pkg::work_type pop_data
);
   import srts_pkg::*;

   work_type entry_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- hdl/srts_back.sv -----
// back end: bit-serial division into digits, then symbol emission
// depends on srts_pkg
`timescale 1ns / 1ps
module srts_back #(
   parameter int unsigned MAX_RADIX = srts_pkg::MaxRadixDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  srts_pkg::cfg_type  cfg,
   input  logic               q_empty,
   output logic               q_pop,
   input  srts_pkg::work_type q_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [srts_pkg::SymbolWidth-1:0] out_symbol,
   output logic               out_last
);
   import srts_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SIGN, S_SIGN_WAIT, S_READ, S_LOAD, S_WAIT
   } state_type;

   state_type state_ff;
   logic neg_ff;
   logic [MagWidth-1:0] mag_ff;
   logic [DigitWidth-1:0] rem_ff;
   logic [CountWidth-1:0] bit_ff;
   logic [CountWidth-1:0] count_ff;
   logic [DigitWidth-1:0] rd_data_ff;
   logic [DigitWidth-1:0] digit_store [MaxDigits];
   logic valid_ff, last_ff;
   logic [SymbolWidth-1:0] symbol_ff;

   logic [RadixWidth-1:0] eff_radix;
   logic [RadixWidth-1:0] shifted_in, rem_in;
   logic ge;
   logic [MagWidth-1:0] mag_in;
   logic digit_done;

   assign eff_radix = (cfg.radix > RadixWidth'(MAX_RADIX)) ?
                      RadixWidth'(MAX_RADIX) : cfg.radix;
   assign shifted_in = {rem_ff, mag_ff[MagWidth-1]};
   assign ge = (shifted_in >= eff_radix);
   assign rem_in = ge ? (shifted_in - eff_radix) : shifted_in;
   assign mag_in = {mag_ff[MagWidth-2:0], ge};
   assign digit_done = (state_ff == S_DIV) && (bit_ff == CountWidth'(MagWidth - 1));

   assign q_pop = (state_ff == S_IDLE) && !q_empty;
   assign out_valid = valid_ff;
   assign out_symbol = symbol_ff;
   assign out_last = last_ff;

   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_store[count_ff] <= rem_in[DigitWidth-1:0];
      end
      rd_data_ff <= digit_store[count_ff - CountWidth'(1)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         last_ff <= 1'b0;
         count_ff <= '0;
         bit_ff <= '0;
         rem_ff <= '0;
         mag_ff <= '0;
         neg_ff <= 1'b0;
         symbol_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  neg_ff <= q_data.neg;
                  mag_ff <= q_data.mag;
                  rem_ff <= '0;
                  bit_ff <= '0;
                  count_ff <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               mag_ff <= mag_in;
               if (digit_done) begin
                  count_ff <= count_ff + CountWidth'(1);
                  rem_ff <= '0;
                  bit_ff <= '0;
                  if (mag_in == '0 || count_ff == CountWidth'(MaxDigits - 1))
                     state_ff <= S_SIGN;
               end else begin
                  rem_ff <= rem_in[DigitWidth-1:0];
                  bit_ff <= bit_ff + CountWidth'(1);
               end
            end
            S_SIGN: begin
               if (neg_ff) begin
                  symbol_ff <= SIGN_MINUS;
                  last_ff <= 1'b0;
                  valid_ff <= 1'b1;
                  state_ff <= S_SIGN_WAIT;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_SIGN_WAIT: begin
               if (out_ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               // digit read registers during this cycle
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               symbol_ff <= symbol_of(cfg.symbols, rd_data_ff);
               last_ff <= (count_ff == CountWidth'(1));
               valid_ff <= 1'b1;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (out_ready) begin
                  valid_ff <= 1'b0;
                  count_ff <= count_ff - CountWidth'(1);
                  state_ff <= (count_ff == CountWidth'(1)) ? S_IDLE : S_READ;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- hdl/srts_checker.sv -----
// port-level checks on the symbol output, bound to the top level
// depends on srts_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srts_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [srts_pkg::SymbolWidth-1:0] rsp_symbol,
   input logic rsp_last
);
   import srts_pkg::*;

   `SRTS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_last), "stalled transaction changed")
   `SRTS_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) && !reset |-> !rsp_valid, "output valid right after reset")
   `SRTS_ASSERT(a_minus_not_last, clock, reset, rsp_valid && rsp_symbol == SIGN_MINUS |-> !rsp_last, "minus sign ends a number")
   `SRTS_ASSERT(a_no_plus, clock, reset, rsp_valid |-> rsp_symbol != SIGN_PLUS, "plus sign emitted")
endmodule

bind signed_radix_to_symbols srts_checker u_srts_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_symbol(rsp_chan.symbol), .rsp_last(rsp_chan.last)
);

// ----- tb/srts_symbol_checker.sv -----
// watches both channels of the radix-to-symbols block, predicts its text and compares
// depends on srts_pkg and the channel interfaces in srts_if
`timescale 1ns / 1ps
module srts_symbol_checker (
   input  logic clock,
   input  logic reset,
   srts_req_if  req_mon,
   srts_rsp_if  rsp_mon,
   input  logic csr_we,
   input  logic [srts_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [srts_pkg::CsrDataWidth-1:0] csr_wdata,
   output int   mismatch_count,
   output int   chars_pending
);
   import srts_pkg::*;

   typedef struct packed {
      logic [SymbolWidth-1:0] symbol;
      logic last;
   } char_type;

   char_type expected_chars[$];
   logic [RadixWidth-1:0] cur_radix;
   logic [2*CsrDataWidth-1:0] cur_table;

   function automatic logic [SymbolWidth-1:0] table_char(input logic [DigitWidth-1:0] d);
      table_char = cur_table[d*SymbolWidth +: SymbolWidth];
   endfunction

   // push the characters one value turns into under the current settings
   task automatic predict_text(input logic [ValueWidth-1:0] v);
      int base;
      int count;
      bit bad;
      logic [ValueWidth-1:0] mag;
      logic [DigitWidth-1:0] digits[MaxDigits];
      char_type c;
      base = (cur_radix > MaxRadixDefault) ? MaxRadixDefault : int'(cur_radix);
      bad = (base < 2);
      for (int i = 0; i < base; i++) begin
         if (table_char(i) == SIGN_PLUS || table_char(i) == SIGN_MINUS) bad = 1;
         for (int j = i + 1; j < base; j++)
            if (table_char(i) == table_char(j)) bad = 1;
      end
      if (bad) return;
      mag = v[ValueWidth-1] ? -v : v;
      if (mag > {1'b0, {MagWidth{1'b1}}}) mag = {1'b0, {MagWidth{1'b1}}};
      count = 0;
      do begin
         digits[count] = DigitWidth'(mag % base);
         mag = mag / base;
         count++;
      end while (mag != 0 && count < MaxDigits);
      if (v[ValueWidth-1]) begin
         c.symbol = SIGN_MINUS;
         c.last = 1'b0;
         expected_chars.push_back(c);
      end
      for (int k = count; k > 0; k--) begin
         c.symbol = table_char(digits[k-1]);
         c.last = (k == 1);
         expected_chars.push_back(c);
      end
   endtask

   always @(posedge clock) begin
      char_type want;
      if (reset) begin
         cur_radix <= '0;
         cur_table <= '0;
         expected_chars.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RADIX: cur_radix <= csr_wdata[RadixWidth-1:0];
               CSR_SYMBOLS_LOW: cur_table[CsrDataWidth-1:0] <= csr_wdata;
               CSR_SYMBOLS_HIGH: cur_table[2*CsrDataWidth-1:CsrDataWidth] <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected char exp none act %h last %b",
                        $time, rsp_mon.symbol, rsp_mon.last);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (want.symbol !== rsp_mon.symbol || want.last !== rsp_mon.last) begin
                  $display("%0t: char mismatch exp %h last %b act %h last %b", $time,
                           want.symbol, want.last, rsp_mon.symbol, rsp_mon.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) predict_text(req_mon.value);
      end
   end

   assign chars_pending = expected_chars.size();
endmodule

// ----- tb/signed_radix_to_symbols_test.sv -----
// stimulus and verdict for the radix-to-symbols block
// depends on srts_pkg, srts_if, the block and srts_symbol_checker
`timescale 1ns / 1ps
module signed_radix_to_symbols_test;
   import srts_pkg::*;

   localparam int DrainCycles = 4600;
   localparam longint CycleLimit = 3000000;
   localparam logic [63:0] DecimalLow = 64'h3736353433323130;
   localparam logic [63:0] HexHigh = 64'h6665646362613938;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   idle_mode_type idle_mode = IDLE_NONE;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   longint cycle_count = 0;
   int mismatch_count;
   int chars_pending;

   srts_req_if req_chan ();
   srts_rsp_if rsp_chan ();

   signed_radix_to_symbols dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   srts_symbol_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .chars_pending(chars_pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls plus a long hold-off on request
   initial rsp_chan.ready = 0;
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= 3000;
         rsp_chan.ready <= 0;
      end else if (idle_mode == IDLE_RECEIVER)
         rsp_chan.ready <= ($urandom_range(99) >= 84);
      else if (idle_mode == IDLE_BOTH)
         rsp_chan.ready <= ($urandom_range(99) >= 29);
      else
         rsp_chan.ready <= 1;
   end

   task automatic write_settings(input logic [4:0] radix_val, input logic [63:0] low,
                                 input logic [63:0] high);
      csr_we <= 1;
      csr_index <= CSR_RADIX;
      csr_wdata <= {59'd0, radix_val};
      @(posedge clock);
      csr_index <= CSR_SYMBOLS_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= CSR_SYMBOLS_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic send_value(input logic [63:0] v);
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 84 : (idle_mode == IDLE_BOTH) ? 29 : 0;
      if ($urandom_range(99) < pct) begin
         req_chan.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
      req_chan.valid <= 1;
      req_chan.value <= v;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // all expected text out, then give the divider time to finish a silent item
   task automatic settle;
      req_chan.valid <= 0;
      // let the checker record the last accepted transaction first
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(5))
         0: v = v;
         1: v = 64'(signed'(64'($urandom_range(40)) - 20));
         2: v = 64'h8000000000000000;
         default: begin
            v = v >> $urandom_range(63);
            if ($urandom_range(1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // distinct symbols, no sign characters; sometimes a deliberate fault
   task automatic random_table(input int base, output logic [127:0] tbl);
      logic [7:0] c;
      bit clash;
      int slot;
      int used;
      tbl = '0;
      used = (base > 16) ? 16 : base;
      for (int i = 0; i < 16; i++) begin
         do begin
            c = 8'($urandom);
            clash = (c == SIGN_PLUS || c == SIGN_MINUS);
            for (int j = 0; j < i; j++) if (tbl[j*8 +: 8] == c) clash = 1;
         end while (clash);
         tbl[i*8 +: 8] = c;
      end
      if (used >= 2 && $urandom_range(7) == 0) begin
         slot = $urandom_range(used - 1);
         case ($urandom_range(2))
            0: tbl[slot*8 +: 8] = SIGN_PLUS;
            1: tbl[slot*8 +: 8] = SIGN_MINUS;
            default: tbl[slot*8 +: 8] = tbl[((slot + 1) % used)*8 +: 8];
         endcase
      end
   endtask

   initial begin
      int base;
      logic [127:0] tbl;
      req_chan.valid = 0;
      req_chan.value = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: radix zero, nothing comes out
      send_value(64'd5);
      send_value(-64'd5);
      settle();

      write_settings(5'd10, DecimalLow, {48'd0, 16'h3938});
      send_value(64'd0);
      send_value(64'd1);
      send_value(-64'd1);
      send_value(64'h7FFFFFFFFFFFFFFF);
      send_value(64'h8000000000000000);
      send_value(-64'd10);
      send_value(64'd9);
      settle();

      // radix above the maximum behaves as sixteen
      write_settings(5'd31, DecimalLow, HexHigh);
      send_value(64'hFFFFFFFFFFFFFFFF);
      send_value(64'h0123456789ABCDEF);
      send_value(64'h8000000000000000);
      settle();

      write_settings(5'd2, 64'h4931, 64'd0);
      send_value(64'd0);
      send_value(64'h7FFFFFFFFFFFFFFF);
      send_value(-64'd6);
      settle();

      // broken tables and a one-symbol radix stay silent
      write_settings(5'd10, 64'h3736353433323130, 64'h3930);
      send_value(64'd123);
      settle();
      write_settings(5'd4, 64'h2B323130, 64'd0);
      send_value(64'd7);
      settle();
      write_settings(5'd3, 64'h2D3130, 64'd0);
      send_value(-64'd7);
      settle();
      write_settings(5'd1, DecimalLow, HexHigh);
      send_value(64'd7);
      settle();

      // long receiver hold-off while values keep coming
      write_settings(5'd16, DecimalLow, HexHigh);
      hold_token <= hold_token + 1;
      for (int i = 0; i < 6; i++) send_value(random_value());
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         idle_mode = idle_mode_type'(ph % 4);
         base = (ph == 7) ? $urandom_range(31) : $urandom_range(3, 16);
         random_table(base, tbl);
         write_settings(5'(base), tbl[63:0], tbl[127:64]);
         for (int i = 0; i < 14; i++) send_value(random_value());
         settle();
      end

      if (mismatch_count == 0 && chars_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/srts_pkg.sv
hdl/srts_if.sv
hdl/srts_front.sv
hdl/srts_queue.sv
hdl/srts_back.sv
hdl/signed_radix_to_symbols.sv
hdl/srts_checker.sv
tb/srts_symbol_checker.sv
tb/signed_radix_to_symbols_test.sv
